// ----- rtl/core/tbn_pkg.sv -----
// ----------------------------------------------------------------------------
// tbn_pkg
// Shared types, constants and byte classification helpers for the text byte
// normalizer.
// ----------------------------------------------------------------------------
package tbn_pkg;

	// Depth of the held space/tab run.
	localparam int PENDING_DEPTH = 32;
	localparam int PCW = $clog2(PENDING_DEPTH + 1);
	localparam int PIW = (PENDING_DEPTH > 1) ? $clog2(PENDING_DEPTH) : 1;

	// Entries in the queue between front and back.
	localparam int QUEUE_DEPTH = 2;

	// Character codes.
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CTRL_TOP = 8'h20;
	localparam logic [7:0] CH_0     = 8'h30;
	localparam logic [7:0] CH_9     = 8'h39;
	localparam logic [7:0] CH_UA    = 8'h41;
	localparam logic [7:0] CH_UZ    = 8'h5A;
	localparam logic [7:0] CH_LA    = 8'h61;
	localparam logic [7:0] CH_LZ    = 8'h7A;

	// Replacement character EF BF BD.
	localparam logic [7:0] REPL_B0 = 8'hEF;
	localparam logic [7:0] REPL_B1 = 8'hBF;
	localparam logic [7:0] REPL_B2 = 8'hBD;

	// Length classes.
	localparam logic [1:0] LC_NORMAL = 2'd0;
	localparam logic [1:0] LC_SHORT  = 2'd1;
	localparam logic [1:0] LC_EMPTY  = 2'd2;

	// Configuration register indexes.
	localparam logic [1:0] CFG_FIX_LINE_ENDINGS   = 2'd0;
	localparam logic [1:0] CFG_STRIP_CONTROLS     = 2'd1;
	localparam logic [1:0] CFG_TRIM_LINE_TAILS    = 2'd2;
	localparam logic [1:0] CFG_SHORT_LENGTH_LIMIT = 2'd3;

	localparam logic [7:0] SHORT_LIMIT_RESET = 8'd20;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       byte_valid;
		logic       end_of_text;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       is_summary;
		logic       last_of_run;
		logic       line_endings_fixed;
		logic       controls_removed;
		logic       whitespace_trimmed;
		logic       high_numeric_ratio;
		logic       high_symbol_ratio;
		logic [1:0] length_class;
		logic       replacement_seen;
		logic       text_changed;
		logic       pending_overflow;
	} out_item_t;

	typedef struct packed {
		logic       fix_line_endings;
		logic       strip_controls;
		logic       trim_line_tails;
		logic [7:0] short_length_limit;
	} cfg_t;

	// One queue entry: a flushed whitespace run, an LF from a held CR,
	// one more byte and the summary, in that order, each optional.
	typedef struct packed {
		logic [PCW-1:0]           flush_cnt;
		logic [PENDING_DEPTH-1:0] flush_kinds;
		logic                     a_lf;
		logic                     b_vld;
		logic [7:0]               b_byte;
		logic                     sum_vld;
		logic                     line_fixed;
		logic                     ctrl_removed;
		logic                     ws_trimmed;
		logic                     overflow;
		logic                     changed;
		logic                     hi_num;
		logic                     hi_sym;
	} cmd_t;

	function automatic logic is_digit(input logic [7:0] c);
		return (c >= CH_0) && (c <= CH_9);
	endfunction

	function automatic logic is_letter(input logic [7:0] c);
		return ((c >= CH_UA) && (c <= CH_UZ)) || ((c >= CH_LA) && (c <= CH_LZ));
	endfunction

	// Anything that is not a digit, a letter, a space or TAB through CR.
	function automatic logic is_symbol(input logic [7:0] c);
		return !is_digit(c) && !is_letter(c) && (c != CH_SPACE) &&
			!((c >= CH_TAB) && (c <= CH_CR));
	endfunction

endpackage

// ----- rtl/core/text_byte_normalizer_core.sv -----
// ----------------------------------------------------------------------------
// text_byte_normalizer_core
// Byte stream text normalizer: line ending repair, control stripping, line
// tail trimming and an end-of-text summary request.
// ----------------------------------------------------------------------------
//
//   Channel | Direction | Handshake             | Payload
//   --------+-----------+-----------------------+---------------------------
//   in      | in        | in_valid / in_stall   | in_data  (in_item_t)
//   out     | out       | out_valid / out_stall | out_data (out_item_t)
//   cfg     | in        | cfg_we                | cfg_index, cfg_wdata
//
// The front takes one input request per cycle whenever the two-entry command
// queue has room, so in_stall is exactly "queue full".
// The back delivers one result request per cycle while the output is not stalled;
// an item that flushes a held whitespace run of n bytes yields up to n + 3
// results, and the back is what sets the sustained rate for such items.
// Reset clears all stream state and restores the register defaults at once;
// there is no clearing pass.
// out_stall only holds the output register and, once the queue fills, the
// input side; neither side loses or repeats a request under any stall pattern.
// ----------------------------------------------------------------------------
module text_byte_normalizer_core import tbn_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_stall,
	input  in_item_t  in_data,
	output logic      out_valid,
	input  logic      out_stall,
	output out_item_t out_data,
	input  logic      cfg_we,
	input  logic [1:0] cfg_index,
	input  logic [7:0] cfg_wdata
);

	cfg_t cfg_q;
	logic in_accept;
	logic q_push;
	logic q_pop;
	logic q_full;
	logic q_nonempty;
	cmd_t q_wr_cmd;
	cmd_t q_head;

	// Configuration registers. Writes must only happen while the block is idle; the block itself does not enforce this.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.fix_line_endings   <= 1'b1;
			cfg_q.strip_controls     <= 1'b1;
			cfg_q.trim_line_tails    <= 1'b1;
			cfg_q.short_length_limit <= SHORT_LIMIT_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_FIX_LINE_ENDINGS:   cfg_q.fix_line_endings   <= cfg_wdata[0];
				CFG_STRIP_CONTROLS:     cfg_q.strip_controls     <= cfg_wdata[0];
				CFG_TRIM_LINE_TAILS:    cfg_q.trim_line_tails    <= cfg_wdata[0];
				CFG_SHORT_LENGTH_LIMIT: cfg_q.short_length_limit <= cfg_wdata;
				default:                cfg_q                    <= cfg_q;
			endcase
		end
	end

	assign in_stall  = q_full;
	assign in_accept = in_valid && !in_stall;

	// The front classifies each accepted byte and posts a command describing
	// every result it causes; items that cause nothing post no command.
	tbn_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_q),
		.accept (in_accept),
		.item   (in_data),
		.push   (q_push),
		.cmd    (q_wr_cmd)
	);

	tbn_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.wr_cmd   (q_wr_cmd),
		.pop      (q_pop),
		.full     (q_full),
		.nonempty (q_nonempty),
		.head     (q_head)
	);

	// The back expands a command into result requests, one per cycle while the output is not stalled.
	tbn_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.head_vld  (q_nonempty),
		.head      (q_head),
		.pop       (q_pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

	// The front never posts into a full queue.
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(q_push && q_full))
		else $error("command pushed into a full queue");

	// The back never retires a command that is not there.
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> q_nonempty)
		else $error("command popped from an empty queue");

	// A summary is always the final result of its input item.
	a_summary_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_data.is_summary) |-> out_data.last_of_run)
		else $error("summary result not marked last");

	// A byte result carries no summary flags.
	a_byte_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_data.is_summary) |->
		(out_data.length_class == LC_NORMAL && !out_data.text_changed))
		else $error("byte result carries summary fields");

endmodule

// ----- rtl/core/tbn_front.sv -----
// ----------------------------------------------------------------------------
// tbn_front
// Accepts raw bytes, resolves CR handling, strips controls, holds the
// whitespace run, keeps the counts and flags and issues queue commands.
// ----------------------------------------------------------------------------
module tbn_front import tbn_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  cfg_t     cfg,
	input  logic     accept,
	input  in_item_t item,
	output logic     push,
	output cmd_t     cmd
);

	logic                     held_cr_q;
	logic [PCW-1:0]           pend_cnt_q;
	logic [PENDING_DEPTH-1:0] pend_kinds_q;
	logic [31:0]              digit_q;
	logic [31:0]              letter_q;
	logic [31:0]              symbol_q;
	logic [33:0]              total_q;
	logic                     line_q;
	logic                     ctrl_q;
	logic                     trimmed_q;
	logic                     over_q;
	logic                     chg_q;

	logic                     held_n;
	logic [PCW-1:0]           cnt_n;
	logic [PENDING_DEPTH-1:0] kinds_n;
	logic [31:0]              digit_n;
	logic [31:0]              letter_n;
	logic [31:0]              symbol_n;
	logic [33:0]              total_n;
	logic                     line_n;
	logic                     ctrl_n;
	logic                     trimmed_n;
	logic                     over_n;
	logic                     chg_n;
	cmd_t                     c;

	always_comb begin
		logic [7:0] b;
		logic       counted;
		b         = item.in_byte;
		counted   = 1'b0;
		held_n    = held_cr_q;
		cnt_n     = pend_cnt_q;
		kinds_n   = pend_kinds_q;
		digit_n   = digit_q;
		letter_n  = letter_q;
		symbol_n  = symbol_q;
		total_n   = total_q;
		line_n    = line_q;
		ctrl_n    = ctrl_q;
		trimmed_n = trimmed_q;
		over_n    = over_q;
		chg_n     = chg_q;
		c         = '0;

		if (item.byte_valid) begin
			// Resolve a CR held from the previous byte.
			if (held_n) begin
				held_n = 1'b0;
				chg_n  = 1'b1;
				if (b != CH_LF) begin
					line_n = 1'b1;
					if (cfg.trim_line_tails) begin
						if (cnt_n != '0) begin
							trimmed_n = 1'b1;
						end
					end else begin
						c.flush_cnt   = cnt_n;
						c.flush_kinds = kinds_n;
					end
					cnt_n   = '0;
					kinds_n = '0;
					c.a_lf  = 1'b1;
				end
			end

			if (cfg.fix_line_endings && (b == CH_CR)) begin
				held_n = 1'b1;
			end else if (cfg.strip_controls && (b < CTRL_TOP) && (b != CH_LF) &&
				(b != CH_TAB)) begin
				ctrl_n = 1'b1;
				chg_n  = 1'b1;
			end else begin
				if (is_digit(b)) begin
					if (digit_n != '1) begin
						digit_n = digit_n + 32'd1;
						counted = 1'b1;
					end
				end else if (is_letter(b)) begin
					if (letter_n != '1) begin
						letter_n = letter_n + 32'd1;
						counted  = 1'b1;
					end
				end else if (is_symbol(b)) begin
					if (symbol_n != '1) begin
						symbol_n = symbol_n + 32'd1;
						counted  = 1'b1;
					end
				end
				if (counted) begin
					total_n = total_n + 34'd1;
				end

				if (((b == CH_SPACE) || (b == CH_TAB)) && cfg.trim_line_tails) begin
					if (cnt_n < PCW'(PENDING_DEPTH)) begin
						kinds_n[cnt_n[PIW-1:0]] = (b == CH_TAB);
						cnt_n = cnt_n + PCW'(1);
					end else begin
						over_n = 1'b1;
						chg_n  = 1'b1;
					end
				end else begin
					if ((b == CH_LF) && cfg.trim_line_tails) begin
						if (cnt_n != '0) begin
							trimmed_n = 1'b1;
							chg_n     = 1'b1;
						end
					end else if (cnt_n != '0) begin
						c.flush_cnt   = cnt_n;
						c.flush_kinds = kinds_n;
					end
					cnt_n    = '0;
					kinds_n  = '0;
					c.b_vld  = 1'b1;
					c.b_byte = b;
				end
			end
		end

		if (item.end_of_text) begin
			// A CR still held at the end becomes LF.
			if (held_n) begin
				held_n = 1'b0;
				line_n = 1'b1;
				chg_n  = 1'b1;
				if (cfg.trim_line_tails) begin
					if (cnt_n != '0) begin
						trimmed_n = 1'b1;
					end
				end else if (cnt_n != '0) begin
					c.flush_cnt   = cnt_n;
					c.flush_kinds = kinds_n;
				end
				cnt_n    = '0;
				kinds_n  = '0;
				c.b_vld  = 1'b1;
				c.b_byte = CH_LF;
			end
			if (cnt_n != '0) begin
				if (cfg.trim_line_tails) begin
					trimmed_n = 1'b1;
					chg_n     = 1'b1;
				end else begin
					c.flush_cnt   = cnt_n;
					c.flush_kinds = kinds_n;
				end
			end
			c.sum_vld      = 1'b1;
			c.line_fixed   = line_n;
			c.ctrl_removed = ctrl_n;
			c.ws_trimmed   = trimmed_n;
			c.overflow     = over_n;
			c.changed      = chg_n;
			c.hi_num       = {1'b0, digit_n, 1'b0} > total_n;
			c.hi_sym       = {1'b0, symbol_n, 1'b0} > total_n;

			// The text is done: everything returns to its reset value.
			held_n    = 1'b0;
			cnt_n     = '0;
			kinds_n   = '0;
			digit_n   = '0;
			letter_n  = '0;
			symbol_n  = '0;
			total_n   = '0;
			line_n    = 1'b0;
			ctrl_n    = 1'b0;
			trimmed_n = 1'b0;
			over_n    = 1'b0;
			chg_n     = 1'b0;
		end
	end

	assign cmd  = c;
	assign push = accept && ((c.flush_cnt != '0) || c.a_lf || c.b_vld || c.sum_vld);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_cr_q    <= 1'b0;
			pend_cnt_q   <= '0;
			pend_kinds_q <= '0;
			digit_q      <= '0;
			letter_q     <= '0;
			symbol_q     <= '0;
			total_q      <= '0;
			line_q       <= 1'b0;
			ctrl_q       <= 1'b0;
			trimmed_q    <= 1'b0;
			over_q       <= 1'b0;
			chg_q        <= 1'b0;
		end else if (accept) begin
			held_cr_q    <= held_n;
			pend_cnt_q   <= cnt_n;
			pend_kinds_q <= kinds_n;
			digit_q      <= digit_n;
			letter_q     <= letter_n;
			symbol_q     <= symbol_n;
			total_q      <= total_n;
			line_q       <= line_n;
			ctrl_q       <= ctrl_n;
			trimmed_q    <= trimmed_n;
			over_q       <= over_n;
			chg_q        <= chg_n;
		end
	end

endmodule

// ----- rtl/core/tbn_queue.sv -----
// ----------------------------------------------------------------------------
// tbn_queue
// Small register queue of commands between the front and the back.
// ----------------------------------------------------------------------------
module tbn_queue import tbn_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t wr_cmd,
	input  logic pop,
	output logic full,
	output logic nonempty,
	output cmd_t head
);

	localparam int QAW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QCW = $clog2(QUEUE_DEPTH + 1);

	cmd_t           slot_q [QUEUE_DEPTH];
	logic [QAW-1:0] wr_ptr_q;
	logic [QAW-1:0] rd_ptr_q;
	logic [QCW-1:0] count_q;

	assign full     = (count_q == QCW'(QUEUE_DEPTH));
	assign nonempty = (count_q != '0);
	assign head     = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= wr_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QAW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + QAW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QAW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + QAW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + QCW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - QCW'(1);
			end
		end
	end

endmodule

// ----- rtl/core/tbn_back.sv -----
// ----------------------------------------------------------------------------
// tbn_back
// Plays out queued commands into the output register, one result per cycle
// while unstalled, and tracks output length and replacement-character match.
// ----------------------------------------------------------------------------
module tbn_back import tbn_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  cfg_t      cfg,
	input  logic      head_vld,
	input  cmd_t      head,
	output logic      pop,
	output logic      out_valid,
	input  logic      out_stall,
	output out_item_t out_data
);

	localparam logic [1:0] PH_FLUSH = 2'd0;
	localparam logic [1:0] PH_LF    = 2'd1;
	localparam logic [1:0] PH_BYTE  = 2'd2;
	localparam logic [1:0] PH_SUM   = 2'd3;

	logic [1:0]     phase_q;
	logic [PCW-1:0] idx_q;
	logic [7:0]     len_q;
	logic [1:0]     match_q;
	logic           repl_q;
	logic           out_valid_q;
	out_item_t      out_q;

	logic [1:0]     eff;
	logic           more_flush;
	logic           last;
	logic           adv;
	logic [7:0]     byte_now;
	out_item_t      res;

	always_comb begin
		if ((phase_q == PH_FLUSH) && (idx_q < head.flush_cnt)) begin
			eff = PH_FLUSH;
		end else if ((phase_q <= PH_LF) && head.a_lf) begin
			eff = PH_LF;
		end else if ((phase_q <= PH_BYTE) && head.b_vld) begin
			eff = PH_BYTE;
		end else begin
			eff = PH_SUM;
		end
		more_flush = (eff == PH_FLUSH) && ((idx_q + PCW'(1)) < head.flush_cnt);
		last = !more_flush && !(head.a_lf && (eff < PH_LF)) &&
			!(head.b_vld && (eff < PH_BYTE)) && !(head.sum_vld && (eff < PH_SUM));
	end

	always_comb begin
		unique case (eff)
			PH_FLUSH: byte_now = head.flush_kinds[idx_q[PIW-1:0]] ? CH_TAB : CH_SPACE;
			PH_LF:    byte_now = CH_LF;
			PH_BYTE:  byte_now = head.b_byte;
			default:  byte_now = 8'd0;
		endcase
	end

	always_comb begin
		res             = '0;
		res.last_of_run = last;
		if (eff == PH_SUM) begin
			res.is_summary         = 1'b1;
			res.line_endings_fixed = head.line_fixed;
			res.controls_removed   = head.ctrl_removed;
			res.whitespace_trimmed = head.ws_trimmed;
			res.high_numeric_ratio = head.hi_num;
			res.high_symbol_ratio  = head.hi_sym;
			res.replacement_seen   = repl_q;
			res.text_changed       = head.changed;
			res.pending_overflow   = head.overflow;
			if (len_q == 8'd0) begin
				res.length_class = LC_EMPTY;
			end else if (len_q < cfg.short_length_limit) begin
				res.length_class = LC_SHORT;
			end else begin
				res.length_class = LC_NORMAL;
			end
		end else begin
			res.out_byte = byte_now;
		end
	end

	assign adv       = head_vld && (!out_valid_q || !out_stall);
	assign pop       = adv && last;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	always_ff @(posedge clk) begin
		if (adv) begin
			out_q <= res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_FLUSH;
			idx_q       <= '0;
			len_q       <= '0;
			match_q     <= '0;
			repl_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (adv) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end

			if (adv) begin
				if (last) begin
					phase_q <= PH_FLUSH;
					idx_q   <= '0;
				end else if (more_flush) begin
					idx_q <= idx_q + PCW'(1);
				end else begin
					phase_q <= eff + 2'd1;
					idx_q   <= '0;
				end

				if (eff == PH_SUM) begin
					len_q   <= '0;
					match_q <= '0;
					repl_q  <= 1'b0;
				end else begin
					if (len_q != 8'hFF) begin
						len_q <= len_q + 8'd1;
					end
					if ((match_q == 2'd2) && (byte_now == REPL_B2)) begin
						repl_q <= 1'b1;
					end
					if (byte_now == REPL_B0) begin
						match_q <= 2'd1;
					end else if ((match_q == 2'd1) && (byte_now == REPL_B1)) begin
						match_q <= 2'd2;
					end else begin
						match_q <= 2'd0;
					end
				end
			end
		end
	end

endmodule
